[hw/rtl/adsr_pkg.sv]
// ----------------------------------------------------------------------------
// ADSR package
// Shared widths, register indexes, reset levels and the command/status
// bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package adsr_pkg;

	localparam int TICK_BITS_DEF = 24;   // default width of the tick index
	localparam int CFG_TICK_BITS = 24;   // width of a length register field
	localparam int LEVEL_BITS    = 16;   // width of every level
	localparam int CFG_DATA_BITS = 24;   // widest register
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PEAK    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 3'd5;

	localparam logic [LEVEL_BITS-1:0] PEAK_RESET    = 16'hFFFF;
	localparam logic [LEVEL_BITS-1:0] SUSTAIN_RESET = 16'h8000;

	typedef struct packed {
		logic load_in;   // transfer accepted: apply restart
		logic eval;      // pick phase, latch operands, advance index
		logic mul;       // form product, seed divider
		logic div_step;  // one restoring division step
		logic out_load;  // write result register
	} adsr_cmd_t;

	typedef struct packed {
		logic need_div;  // current tick lies on a ramp
		logic out_free;  // result register can take a new value
	} adsr_status_t;

endpackage

[hw/rtl/adsr_if.sv]
// ----------------------------------------------------------------------------
// ADSR channel interfaces
// Tick channel (restart flag) and level channel (level, running flag),
// each a valid/ready stream.
// ----------------------------------------------------------------------------
interface adsr_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface adsr_level_if;
	import adsr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] level;
	logic                  running;

	modport source (output valid, output level, output running, input ready);
	modport sink   (input valid, input level, input running, output ready);
endinterface

[hw/rtl/adsr_ctrl.sv]
// ----------------------------------------------------------------------------
// ADSR sequencer
// Steps each tick through evaluate, multiply and divide on a ramp, and result write.
// ----------------------------------------------------------------------------
module adsr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  adsr_pkg::adsr_status_t st,
	output adsr_pkg::adsr_cmd_t    cmd
);
	import adsr_pkg::*;

	localparam int CNT_W = $clog2(LEVEL_BITS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             last_step;

	assign in_ready  = (state_q == S_IDLE);
	assign last_step = (cnt_q == CNT_W'(LEVEL_BITS - 1));

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = st.need_div ? S_MUL : S_DONE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (last_step)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.mul)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

[hw/rtl/adsr_datapath.sv]
// ----------------------------------------------------------------------------
// ADSR datapath
// Register file, tick state, phase select, multiplier, restoring divider
// and result register.
// ----------------------------------------------------------------------------
module adsr_datapath #(
	parameter int TICK_BITS = adsr_pkg::TICK_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [adsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [adsr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                restart,
	input  adsr_pkg::adsr_cmd_t                 cmd,
	output adsr_pkg::adsr_status_t              st,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [adsr_pkg::LEVEL_BITS-1:0]     level,
	output logic                                running
);
	import adsr_pkg::*;

	localparam int TW = TICK_BITS;
	localparam int CW = (TICK_BITS < CFG_TICK_BITS) ? TICK_BITS : CFG_TICK_BITS;
	localparam int XW = TICK_BITS + 1;
	localparam int LW = LEVEL_BITS;

	// register file
	logic [CW-1:0] attack_q, decay_q, release_q, total_q;
	logic [LW-1:0] peak_q, sustain_q;

	// tick state
	logic [TW-1:0] idx_q;
	logic          active_q;

	// operands latched at evaluate
	logic [LW-1:0] opa_q;
	logic [CW-1:0] opb_q;
	logic [CW-1:0] dvs_q;
	logic [LW-1:0] base_q;
	logic          sub_q;
	logic          use_div_q;
	logic          run_q;

	// divider
	logic [CW-1:0] rem_q;
	logic [LW-1:0] quo_q;

	// result register
	logic          out_valid_q;
	logic [LW-1:0] level_q;
	logic          running_q;

	// phase select
	logic [CW-1:0] tot_eff, rel_start;
	logic [XW-1:0] idx_x, att_x, ad_x, rs_x, dec_span, rel_span;
	logic          ends, live;
	logic [LW-1:0] opa_d, base_d;
	logic [CW-1:0] opb_d, dvs_d;
	logic          sub_d, ramp_d;

	logic [LW+CW-1:0] prod;
	logic [CW:0]      trial, trial_sub;
	logic             ge;
	logic [LW-1:0]    result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			release_q <= '0;
			total_q   <= '0;
			peak_q    <= PEAK_RESET;
			sustain_q <= SUSTAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTACK:  attack_q  <= cfg_data[CW-1:0];
				REG_DECAY:   decay_q   <= cfg_data[CW-1:0];
				REG_RELEASE: release_q <= cfg_data[CW-1:0];
				REG_TOTAL:   total_q   <= cfg_data[CW-1:0];
				REG_PEAK:    peak_q    <= cfg_data[LW-1:0];
				REG_SUSTAIN: sustain_q <= cfg_data[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		tot_eff   = (total_q < release_q) ? '0 : total_q;
		rel_start = tot_eff - release_q;
		idx_x     = XW'(idx_q);
		att_x     = XW'(attack_q);
		ad_x      = XW'(attack_q) + XW'(decay_q);
		rs_x      = XW'(rel_start);
		dec_span  = idx_x - att_x;
		rel_span  = idx_x - rs_x;
		ends      = (idx_q >= TW'(tot_eff));
		live      = active_q && !ends;

		opa_d  = peak_q;
		opb_d  = CW'(idx_q);
		dvs_d  = attack_q;
		base_d = '0;
		sub_d  = 1'b0;
		ramp_d = 1'b0;
		if (!live) begin
			base_d = '0;
		end else if (idx_x <= att_x) begin
			if (attack_q == '0)
				base_d = peak_q;
			else
				ramp_d = 1'b1;
		end else if (idx_x <= ad_x) begin
			// decay: magnitude through the divider, sign applied at the end
			ramp_d = 1'b1;
			base_d = peak_q;
			opb_d  = CW'(dec_span);
			dvs_d  = decay_q;
			if (sustain_q >= peak_q) begin
				opa_d = sustain_q - peak_q;
			end else begin
				opa_d = peak_q - sustain_q;
				sub_d = 1'b1;
			end
		end else if (idx_x <= rs_x) begin
			base_d = sustain_q;
		end else begin
			ramp_d = 1'b1;
			base_d = sustain_q;
			opa_d  = sustain_q;
			opb_d  = CW'(rel_span);
			dvs_d  = release_q;
			sub_d  = 1'b1;
		end
	end

	assign st.need_div = ramp_d;
	assign st.out_free = !out_valid_q || out_ready;

	// the product's top part is below the divisor, so LW steps give the quotient
	assign prod      = (LW+CW)'(opa_q) * (LW+CW)'(opb_q);
	assign trial     = {rem_q, quo_q[LW-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign ge        = (trial >= {1'b0, dvs_q});

	always_comb begin
		if (!use_div_q)
			result = base_q;
		else if (sub_q)
			result = base_q - quo_q;
		else
			result = base_q + quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			active_q <= 1'b0;
		end else if (cmd.load_in) begin
			if (restart) begin
				idx_q    <= '0;
				active_q <= 1'b1;
			end
		end else if (cmd.eval) begin
			if (active_q) begin
				if (ends)
					active_q <= 1'b0;
				else
					idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			opa_q     <= opa_d;
			opb_q     <= opb_d;
			dvs_q     <= dvs_d;
			base_q    <= base_d;
			sub_q     <= sub_d;
			use_div_q <= ramp_d;
			run_q     <= live;
		end
		if (cmd.mul) begin
			rem_q <= prod[LW+CW-1:LW];
			quo_q <= prod[LW-1:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
			quo_q <= {quo_q[LW-2:0], ge};
		end
		if (cmd.out_load) begin
			level_q   <= result;
			running_q <= run_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign running   = running_q;

endmodule

[hw/rtl/adsr_envelope_generator_top.sv]
// Linear ADSR envelope generator: one level per control tick.
// Ticks are taken one at a time; a ramp tick (attack, decay, release) runs through
//   the 16-step restoring divider, while a flat tick skips it.
// The result is registered and turns valid at the result write, which waits while
//   the result register is still held by the sink.
// Reset (arst_n low, asynchronous): envelope inactive, index 0, registers at defaults.
// ----------------------------------------------------------------------------
// ADSR envelope generator, top level
// Ties the sequencer and the datapath to the tick and level channels and
// the register write port.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_top #(
	parameter int TICK_BITS = adsr_pkg::TICK_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [adsr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [adsr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	adsr_tick_if.sink                          tick_ch,
	adsr_level_if.source                       level_ch
);
	import adsr_pkg::*;

	// Command/status bundle: the sequencer decides when, the datapath what.
	adsr_cmd_t    cmd;
	adsr_status_t st;

	// Sequencer: takes a tick transfer only when idle, then walks
	// evaluate -> multiply -> 16 divide steps -> result write. Flat ticks
	// (sustain, zero attack, inactive, end of envelope) skip straight to
	// the result write.
	adsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tick_ch.valid),
		.in_ready (tick_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: holds the registers, the tick index and active flag, the
	// 16xN multiplier and the divider. The result register decouples the
	// level channel, so a new tick is taken while a level waits.
	adsr_datapath #(
		.TICK_BITS (TICK_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (tick_ch.restart),
		.cmd       (cmd),
		.st        (st),
		.out_valid (level_ch.valid),
		.out_ready (level_ch.ready),
		.level     (level_ch.level),
		.running   (level_ch.running)
	);

endmodule

[hw/rtl/adsr_checker.sv]
// ----------------------------------------------------------------------------
// ADSR port checker
// Watches the channel ports of the envelope generator over time.
// ----------------------------------------------------------------------------
module adsr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [adsr_pkg::LEVEL_BITS-1:0] level,
	input logic                           running
);
	import adsr_pkg::*;

	// a held level must not change under back-pressure
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(running))
		else $error("level changed while stalled");

	// a finished envelope gives silence
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> level == '0)
		else $error("non-zero level with envelope stopped");

	// one tick in flight: the tick channel closes after each transfer
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("tick taken while another is in work");

	// a new level only appears after the tick channel has been closed
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("level produced without a tick in work");

endmodule

bind adsr_envelope_generator_top adsr_checker u_adsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tick_ch.valid),
	.in_ready  (tick_ch.ready),
	.out_valid (level_ch.valid),
	.out_ready (level_ch.ready),
	.level     (level_ch.level),
	.running   (level_ch.running)
);
